>>> sv/krs_pkg.sv
package krs_pkg;

   // Alphabet geometry of the cipher.
   localparam int ALPHA_LEN = 26;
   localparam int HALF_LEN  = 13;
   localparam int IDX_W     = 5;
   localparam int BYTE_W    = 8;

   // Item modes.
   localparam logic [1:0] MODE_KEY   = 2'd0;
   localparam logic [1:0] MODE_TEXT  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // ASCII anchors; lowercase sits one case gap above uppercase.
   localparam logic [7:0] CASE_GAP = 8'd32;
   localparam logic [7:0] UPPER_A  = 8'd65;
   localparam logic [7:0] UPPER_Z  = 8'd90;
   localparam logic [7:0] LOWER_A  = UPPER_A + CASE_GAP;
   localparam logic [7:0] LOWER_Z  = UPPER_Z + CASE_GAP;

   // Control broadcast from the top level to every cell of the chain.
   typedef struct packed {
      logic             add_en;
      logic             clear;
      logic [IDX_W-1:0] letter;
      logic [IDX_W-1:0] count;
      logic [IDX_W-1:0] probe;
   } krs_ctl_type;

endpackage

>>> sv/krs_cell.sv
// One slot of the cipher alphabet. The chain of cells holds the full letter
// order; adding a keyword letter shifts part of the unused tail one slot up.
module krs_cell #(
   parameter int POS = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  krs_pkg::krs_ctl_type        ctl,
   input  logic [krs_pkg::IDX_W-1:0]   left_value,
   input  logic [krs_pkg::IDX_W-1:0]   partner_value,
   output logic [krs_pkg::IDX_W-1:0]   value,
   output logic [krs_pkg::IDX_W-1:0]   candidate
);

   localparam logic [krs_pkg::IDX_W-1:0] POS_CODE = POS[krs_pkg::IDX_W-1:0];

   logic [krs_pkg::IDX_W-1:0] value_ff;
   logic [krs_pkg::IDX_W-1:0] value_in;

   // The unused tail is sorted, so this slot lies between the keyword end
   // and the new letter's old slot exactly when its left neighbor is smaller.
   always_comb begin
      value_in = value_ff;
      if (ctl.clear) begin
         value_in = POS_CODE;
      end else if (ctl.add_en) begin
         if (POS_CODE == ctl.count) begin
            value_in = ctl.letter;
         end else if ((POS_CODE > ctl.count) && (left_value < ctl.letter)) begin
            value_in = left_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= POS_CODE;
      end else begin
         value_ff <= value_in;
      end
   end

   // A slot that holds the probed letter offers its partner's letter.
   assign value     = value_ff;
   assign candidate = (value_ff == ctl.probe) ? partner_value : '0;

endmodule

>>> sv/krs_out_buf.sv
// Output register with a skid stage, so an item can be taken while a
// finished result still waits.
module krs_out_buf (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [krs_pkg::BYTE_W-1:0]   push_data,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output logic [krs_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                         full
);

   logic                        out_valid_ff;
   logic [krs_pkg::BYTE_W-1:0]  out_data_ff;
   logic                        skid_valid_ff;
   logic [krs_pkg::BYTE_W-1:0]  skid_data_ff;
   logic                        pop;

   assign pop = out_valid_ff && !rsp_stall;

   // Control bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload moves with the control bits and needs no reset.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_valid_ff || pop) begin
         if (push) begin
            out_data_ff <= push_data;
         end
      end else if (push) begin
         skid_data_ff <= push_data;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_data_ff;
   assign full         = skid_valid_ff;

endmodule

>>> sv/keyword_reciprocal_substitution_core.sv
// Keyword-mixed reciprocal substitution cipher. Keyword items (mode 0) add
// an uppercase letter that is not yet in the keyword; other keyword bytes are
// dropped. The alphabet order is the keyword letters in arrival order, then
// the unused letters alphabetically, and slot p pairs with slot p+13 mod 26.
// Text items (mode 1) each return one byte: a letter becomes its partner in
// the same case, anything else passes unchanged. A clear item (mode 2) empties
// the keyword, which gives plain ROT13; mode 3 is ignored. One item is taken
// every cycle unless req_stall is high, keyword and text alike, since the
// 26-slot chain updates all slots together and the partner lookup is a single
// select across the chain. A text result goes to the output register, or to
// its skid stage if that is busy; req_stall rises only when both hold results.
module keyword_reciprocal_substitution_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_mode,
   input  logic [krs_pkg::BYTE_W-1:0]   req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [krs_pkg::BYTE_W-1:0]   rsp_out_byte
);

   localparam int N = krs_pkg::ALPHA_LEN;
   localparam int W = krs_pkg::IDX_W;

   logic [N-1:0]        used_ff;
   logic [N-1:0]        used_in;
   logic [W-1:0]        count_ff;
   logic [W-1:0]        count_in;
   logic                accept;
   logic                is_upper;
   logic                is_lower;
   logic [W-1:0]        probe;
   logic [W-1:0]        partner;
   logic [krs_pkg::BYTE_W-1:0] result;
   logic                full;
   krs_pkg::krs_ctl_type ctl;
   logic [W-1:0]        order [N];
   logic [W-1:0]        cand  [N];

   assign accept   = req_valid && !req_stall;
   assign req_stall = full;

   // Classify the byte and form its letter index.
   assign is_upper = (req_value >= krs_pkg::UPPER_A) && (req_value <= krs_pkg::UPPER_Z);
   assign is_lower = (req_value >= krs_pkg::LOWER_A) && (req_value <= krs_pkg::LOWER_Z);
   assign probe    = is_upper ? W'(req_value - krs_pkg::UPPER_A)
                              : W'(req_value - krs_pkg::LOWER_A);

   // Broadcast control for the chain.
   always_comb begin
      ctl.add_en = accept && (req_mode == krs_pkg::MODE_KEY) && is_upper
                   && !used_ff[probe] && (count_ff < W'(N));
      ctl.clear  = accept && (req_mode == krs_pkg::MODE_CLEAR);
      ctl.letter = probe;
      ctl.count  = count_ff;
      ctl.probe  = probe;
   end

   // Keyword bookkeeping.
   always_comb begin
      used_in  = used_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         used_in  = '0;
         count_in = '0;
      end else if (ctl.add_en) begin
         used_in[probe] = 1'b1;
         count_in       = count_ff + W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         count_ff <= '0;
      end else begin
         used_ff  <= used_in;
         count_ff <= count_in;
      end
   end

   // The chain of alphabet slots.
   for (genvar p = 0; p < N; p++) begin : g_cell
      krs_cell #(
         .POS (p)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .left_value    ((p == 0) ? W'(0) : order[(p + N - 1) % N]),
         .partner_value (order[(p + krs_pkg::HALF_LEN) % N]),
         .value         (order[p]),
         .candidate     (cand[p])
      );
   end

   // Exactly one slot matches a letter, so an OR gathers its partner.
   always_comb begin
      partner = '0;
      for (int p = 0; p < N; p++) begin
         partner = partner | cand[p];
      end
   end

   always_comb begin
      if (is_upper) begin
         result = krs_pkg::UPPER_A + {3'b000, partner};
      end else if (is_lower) begin
         result = krs_pkg::LOWER_A + {3'b000, partner};
      end else begin
         result = req_value;
      end
   end

   krs_out_buf u_out_buf (
      .clock        (clock),
      .reset        (reset),
      .push         (accept && (req_mode == krs_pkg::MODE_TEXT)),
      .push_data    (result),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .full         (full)
   );

endmodule

>>> sv/krs_checker.sv
// Port-level checks for the cipher core.
module krs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [1:0]                   req_mode,
   input logic [krs_pkg::BYTE_W-1:0]   req_value,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [krs_pkg::BYTE_W-1:0]   rsp_out_byte
);

   logic direct;
   logic text_in;

   // An item goes straight to the output register when it is free or draining.
   assign direct  = req_valid && !req_stall && (!rsp_valid || !rsp_stall);
   assign text_in = req_mode == krs_pkg::MODE_TEXT;

   // A stalled result holds.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte))
      else $error("stalled result changed");

   // Reset empties the output.
   a_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A non-letter text byte passes through unchanged.
   a_pass : assert property (@(posedge clock) disable iff (reset)
      direct && text_in
      && !((req_value >= krs_pkg::UPPER_A) && (req_value <= krs_pkg::UPPER_Z))
      && !((req_value >= krs_pkg::LOWER_A) && (req_value <= krs_pkg::LOWER_Z))
      |=> rsp_valid && (rsp_out_byte == $past(req_value)))
      else $error("non-letter byte altered");

   // An uppercase letter stays uppercase.
   a_case : assert property (@(posedge clock) disable iff (reset)
      direct && text_in
      && (req_value >= krs_pkg::UPPER_A) && (req_value <= krs_pkg::UPPER_Z)
      |=> rsp_valid && (rsp_out_byte >= krs_pkg::UPPER_A)
      && (rsp_out_byte <= krs_pkg::UPPER_Z))
      else $error("letter case lost");

   // Keyword, clear and mode 3 items taken while the output is empty give no result.
   a_silent : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && !req_stall && !text_in |=> !rsp_valid)
      else $error("result from a non-text item");

endmodule

bind keyword_reciprocal_substitution_core krs_checker u_krs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_mode     (req_mode),
   .req_value    (req_value),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte)
);
